// File: rtl/core/assert_macros.svh
// Assertion helpers for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSTT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define MSTT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/mstt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstt_pkg: shared types and constants of the multi-shot timer table
// Holds the timer record that moves through the cell ring, the evaluation
// result of one timer, and the command and result codes.
// ----------------------------------------------------------------------------
package mstt_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int MAX_ACTIVE_RESET = 16;
    localparam logic [19:0] SLEEP_NONE = 20'd1000000;
    localparam logic [31:0] ID_WRAP = 32'hFFFF_FFFF;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_STOP = 2'd1;
    localparam logic [1:0] CMD_STOP_ALL = 2'd2;
    localparam logic [1:0] CMD_TICK = 2'd3;

    localparam logic [2:0] KIND_ADD_OK = 3'd0;
    localparam logic [2:0] KIND_ADD_REFUSED = 3'd1;
    localparam logic [2:0] KIND_STOP_DONE = 3'd2;
    localparam logic [2:0] KIND_CLEAR_DONE = 3'd3;
    localparam logic [2:0] KIND_EXPIRY = 3'd4;
    localparam logic [2:0] KIND_TICK_DONE = 3'd5;

    typedef struct packed {
        logic        valid;
        logic [31:0] id;
        logic [31:0] interval;
        logic [47:0] start;
        logic [15:0] fired;
        logic [15:0] total;
    } timer_t;

    typedef struct packed {
        logic        expire;
        logic        remove;
        logic [15:0] fired;
        logic [47:0] start;
        logic [48:0] left;
    } eval_t;

endpackage

// File: rtl/core/mstt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstt_cell: one timer slot of the ring
// Holds one timer record and takes its neighbor's record when the ring moves.
// ----------------------------------------------------------------------------
module mstt_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            shift_en,
    input  logic            clear_all,
    input  mstt_pkg::timer_t din,
    output mstt_pkg::timer_t dout
);

    logic             valid_reg;
    mstt_pkg::timer_t data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (clear_all) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= din.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            data_reg <= din;
        end
    end

    always_comb begin
        dout       = data_reg;
        dout.valid = valid_reg;
    end

endmodule

// File: rtl/core/mstt_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstt_eval: tick evaluation of the timer at the ring head
// Decides expiry, the new fire count and start time, and the time left.
// ----------------------------------------------------------------------------
module mstt_eval (
    input  mstt_pkg::timer_t tmr,
    input  logic [47:0]      now,
    output mstt_pkg::eval_t  res
);

    logic        late;
    logic [47:0] elapsed;
    logic [15:0] fired_inc;
    logic [15:0] total_eff;

    always_comb begin
        late      = now < tmr.start;
        elapsed   = now - tmr.start;
        fired_inc = tmr.fired + 16'd1;
        total_eff = (tmr.total == 16'd0) ? 16'd1 : tmr.total;
        res       = '0;
        res.fired = tmr.fired;
        res.start = tmr.start;
        if (late) begin
            res.left = 49'(tmr.interval) + 49'(tmr.start - now);
        end else if (elapsed < 48'(tmr.interval)) begin
            res.left = 49'(tmr.interval - elapsed[31:0]);
        end else begin
            res.expire = 1'b1;
            res.fired  = fired_inc;
            res.remove = fired_inc >= total_eff;
            res.start  = now;
            res.left   = 49'(tmr.interval);
        end
    end

endmodule

// File: rtl/core/multi_shot_timer_table.sv
`timescale 1ns / 1ps
// An add makes a search pass round the ring and, unless refused, a write pass;
// a stop makes one pass; stop-all clears all slots at once. A tick makes a pass
// to find the lowest id, then one per active timer, each evaluating the timer
// chosen by the pass before. The ring stops while an expiry waits on m_tready.
// One request at a time: a new one is taken only after the final result is loaded.
// Reset: synchronous, active low; clears all slots, next id to one, limit 16.
// ----------------------------------------------------------------------------
// multi_shot_timer_table: table of repeating software timers
// Timers sit in a ring of cells that turns one place per cycle in a scan, held
// while an expiry waits; a single head stage searches, inserts, removes, evaluates.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_shot_timer_table #(
    parameter int SLOTS = mstt_pkg::SLOTS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration: max_active, written whenever cfg_wr_en is high.
    input  logic         cfg_wr_en,
    input  logic [4:0]   cfg_wr_data,
    // Request channel.
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: interval_ms[31:0], repeat_count[47:32], timer_id[79:48],
    // now_ms[127:80]
    input  logic [127:0] s_tdata,
    // tuser: command[1:0]
    input  logic [1:0]   s_tuser,
    // Result channel.
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: result_id[31:0], fire_count[47:32], sleep_ms[67:48], zero[71:68]
    output logic [71:0]  m_tdata,
    // tuser: kind[2:0]
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);

    localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int UW = $clog2(SLOTS + 1);
    localparam int CW = (UW > 5) ? UW : 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_SCAN,
        ST_ADD_WRITE,
        ST_STOP_SCAN,
        ST_TICK_SCAN,
        ST_DONE
    } state_t;

    state_t state_reg;

    // Request fields, held for the whole request.
    logic [31:0] req_interval_reg;
    logic [15:0] req_repeat_reg;
    logic [31:0] req_id_reg;
    logic [47:0] req_now_reg;

    logic [4:0]    max_active_reg;
    logic [31:0]   next_id_reg;
    logic [PW-1:0] cnt_reg;
    logic [UW-1:0] used_reg;
    logic          match_reg;
    logic          written_reg;
    logic [31:0]   target_reg;
    logic          have_target_reg;
    logic          found_reg;
    logic [31:0]   min_reg;
    logic [19:0]   sleep_reg;
    logic [2:0]    done_kind_reg;
    logic [31:0]   done_id_reg;

    logic          m_tvalid_reg;
    logic [2:0]    m_kind_reg;
    logic [31:0]   m_id_reg;
    logic [15:0]   m_fire_reg;
    logic [19:0]   m_sleep_reg;
    logic          m_last_reg;

    // Ring of cells: cell 0 is the head, the modified head re-enters at the tail.
    mstt_pkg::timer_t ring_q [SLOTS];
    mstt_pkg::timer_t ring_d [SLOTS];
    mstt_pkg::timer_t head;
    mstt_pkg::timer_t head_next;
    mstt_pkg::eval_t  ev;

    logic          accept;
    logic          clear_all;
    logic          shift_en;
    logic          go;
    logic          out_free;
    logic          pass_end;
    logic [31:0]   nid_inc;
    logic [31:0]   cand_id;
    logic [UW-1:0] used_sum;
    logic          full;
    logic          hit;
    logic          emit_exp;
    logic          cand_ok;
    logic          found_next;
    logic [31:0]   min_next;
    logic [19:0]   sleep_next;
    logic          out_is_expiry;

    assign head = ring_q[0];

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++) begin : g_cell
            if (gi == SLOTS - 1) begin : g_tail
                assign ring_d[gi] = head_next;
            end else begin : g_mid
                assign ring_d[gi] = ring_q[gi + 1];
            end
            mstt_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .shift_en  (shift_en),
                .clear_all (clear_all),
                .din       (ring_d[gi]),
                .dout      (ring_q[gi])
            );
        end
    endgenerate

    mstt_eval u_eval (
        .tmr (head),
        .now (req_now_reg),
        .res (ev)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign clear_all = accept && (s_tuser == mstt_pkg::CMD_STOP_ALL);
    assign out_free = !m_tvalid_reg || m_tready;
    assign pass_end = (cnt_reg == PW'(SLOTS - 1));

    assign nid_inc = next_id_reg + 32'd1;
    assign cand_id = (nid_inc == mstt_pkg::ID_WRAP) ? 32'd1 : nid_inc;
    assign used_sum = used_reg + UW'(head.valid);
    assign full = (CW'(used_sum) >= CW'(max_active_reg)) || (32'(used_sum) >= 32'(SLOTS));

    // The head timer is evaluated when it is the one chosen by the previous pass.
    assign hit = (state_reg == ST_TICK_SCAN) && head.valid && have_target_reg
                 && (head.id == target_reg);
    assign emit_exp = hit && ev.expire;
    // The ring stops while an expiry waits for room in the output register.
    assign go = !(emit_exp && !out_free);
    assign shift_en = go && (state_reg == ST_ADD_SCAN || state_reg == ST_ADD_WRITE
                             || state_reg == ST_STOP_SCAN || state_reg == ST_TICK_SCAN);

    // Search for the smallest id above the current target.
    assign cand_ok = head.valid && (!have_target_reg || head.id > target_reg);
    assign found_next = found_reg || cand_ok;
    assign min_next = (cand_ok && (!found_reg || head.id < min_reg)) ? head.id : min_reg;

    always_comb begin
        sleep_next = sleep_reg;
        if (hit && !(ev.expire && ev.remove) && ev.left != 49'd0
            && ev.left < 49'(sleep_reg)) begin
            sleep_next = ev.left[19:0];
        end
    end

    always_comb begin
        head_next = head;
        case (state_reg)
            ST_ADD_WRITE: begin
                if (!head.valid && !written_reg) begin
                    head_next.valid    = 1'b1;
                    head_next.id       = next_id_reg;
                    head_next.interval = req_interval_reg;
                    head_next.start    = req_now_reg;
                    head_next.fired    = 16'd0;
                    head_next.total    = req_repeat_reg;
                end
            end
            ST_STOP_SCAN: begin
                if (head.valid && head.id == req_id_reg) begin
                    head_next.valid = 1'b0;
                end
            end
            ST_TICK_SCAN: begin
                if (hit) begin
                    head_next.start = ev.start;
                    head_next.fired = ev.fired;
                    head_next.valid = !(ev.expire && ev.remove);
                end
            end
            default: begin
                head_next = head;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            max_active_reg  <= 5'(mstt_pkg::MAX_ACTIVE_RESET);
            next_id_reg     <= 32'd1;
            m_tvalid_reg    <= 1'b0;
            cnt_reg         <= '0;
            used_reg        <= '0;
            match_reg       <= 1'b0;
            written_reg     <= 1'b0;
            have_target_reg <= 1'b0;
            found_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_active_reg <= cfg_wr_data;
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (shift_en) begin
                cnt_reg <= pass_end ? '0 : cnt_reg + PW'(1);
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        req_interval_reg <= s_tdata[31:0];
                        req_repeat_reg   <= s_tdata[47:32];
                        req_id_reg       <= s_tdata[79:48];
                        req_now_reg      <= s_tdata[127:80];
                        cnt_reg          <= '0;
                        used_reg         <= '0;
                        match_reg        <= 1'b0;
                        written_reg      <= 1'b0;
                        have_target_reg  <= 1'b0;
                        found_reg        <= 1'b0;
                        sleep_reg        <= mstt_pkg::SLEEP_NONE;
                        done_id_reg      <= 32'd0;
                        unique case (s_tuser)
                            mstt_pkg::CMD_ADD:  state_reg <= ST_ADD_SCAN;
                            mstt_pkg::CMD_STOP: state_reg <= ST_STOP_SCAN;
                            mstt_pkg::CMD_TICK: state_reg <= ST_TICK_SCAN;
                            default: begin
                                done_kind_reg <= mstt_pkg::KIND_CLEAR_DONE;
                                state_reg     <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_ADD_SCAN: begin
                    used_reg  <= used_sum;
                    match_reg <= match_reg || (head.valid && head.id == cand_id);
                    if (pass_end) begin
                        state_reg     <= ST_DONE;
                        done_kind_reg <= mstt_pkg::KIND_ADD_REFUSED;
                        if (!full) begin
                            next_id_reg <= cand_id;
                            if (!(match_reg || (head.valid && head.id == cand_id))) begin
                                state_reg <= ST_ADD_WRITE;
                            end
                        end
                    end
                end
                ST_ADD_WRITE: begin
                    if (!head.valid) begin
                        written_reg <= 1'b1;
                    end
                    if (pass_end) begin
                        done_kind_reg <= mstt_pkg::KIND_ADD_OK;
                        done_id_reg   <= next_id_reg;
                        state_reg     <= ST_DONE;
                    end
                end
                ST_STOP_SCAN: begin
                    if (pass_end) begin
                        done_kind_reg <= mstt_pkg::KIND_STOP_DONE;
                        state_reg     <= ST_DONE;
                    end
                end
                ST_TICK_SCAN: begin
                    if (go) begin
                        sleep_reg <= sleep_next;
                        found_reg <= found_next;
                        min_reg   <= min_next;
                        if (emit_exp) begin
                            m_tvalid_reg <= 1'b1;
                            m_kind_reg   <= mstt_pkg::KIND_EXPIRY;
                            m_id_reg     <= head.id;
                            m_fire_reg   <= ev.fired;
                            m_sleep_reg  <= 20'd0;
                            m_last_reg   <= 1'b0;
                        end
                        if (pass_end) begin
                            found_reg <= 1'b0;
                            if (found_next) begin
                                target_reg      <= min_next;
                                have_target_reg <= 1'b1;
                            end else begin
                                done_kind_reg <= mstt_pkg::KIND_TICK_DONE;
                                state_reg     <= ST_DONE;
                            end
                        end
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_kind_reg   <= done_kind_reg;
                        m_id_reg     <= done_id_reg;
                        m_fire_reg   <= 16'd0;
                        m_sleep_reg  <= (done_kind_reg == mstt_pkg::KIND_TICK_DONE)
                                        ? sleep_reg : 20'd0;
                        m_last_reg   <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {4'd0, m_sleep_reg, m_fire_reg, m_id_reg};

    assign out_is_expiry = m_tvalid && (m_tuser == mstt_pkg::KIND_EXPIRY);

    // An accepted request always leaves the block busy in the cycle after it.
    `MSTT_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, accept, !s_tready)
    // Expiry results are never the final result of a request.
    `MSTT_ASSERT_IMPL(a_expiry_not_last, aclk, aresetn, out_is_expiry, !m_tlast)
    // A stalled expiry freezes the ring position.
    `MSTT_ASSERT_NEXT(a_stall_holds_ring, aclk, aresetn, emit_exp && !out_free, $stable(cnt_reg))

endmodule

// File: tb/multi_shot_timer_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_shot_timer_table_tb: self-checking bench for the repeating timer table
// Drives add, stop, stop-all and tick requests in bursts while the result side
// stalls on its own pattern. A behavioral timer table inside the bench works
// out every result of each accepted request, and a checker compares the
// results that come out, in order, field by field.
// ----------------------------------------------------------------------------
module multi_shot_timer_table_tb;
    import mstt_pkg::*;

    localparam int NSLOT = SLOTS_DEF;
    localparam int IDLE_WAIT = 2 * NSLOT + 40;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] interval;
        logic [15:0] repeats;
        logic [31:0] tid;
        logic [47:0] now;
    } req_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] rid;
        logic [15:0] fires;
        logic [19:0] sleep;
        logic        last;
    } res_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [4:0]   cfg_wr_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // tdata: interval_ms, repeat_count, timer_id, now_ms (lowest bits first)
    logic [127:0] s_tdata = '0;
    // tuser: command
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // tdata: result_id, fire_count, sleep_ms, zero fill (lowest bits first)
    logic [71:0]  m_tdata;
    // tuser: kind
    logic [2:0]   m_tuser;
    logic         m_tlast;

    multi_shot_timer_table dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always #5 aclk = ~aclk;

    // Shadow copy of the timer table, updated as each request is accepted.
    bit          slot_on [NSLOT];
    logic [31:0] slot_tid [NSLOT];
    logic [31:0] slot_period [NSLOT];
    logic [47:0] slot_begin [NSLOT];
    logic [15:0] slot_fires [NSLOT];
    logic [15:0] slot_total [NSLOT];
    logic [31:0] id_counter = 32'd1;
    logic [4:0]  active_limit = 5'd16;

    res_t        pending_results [$];
    logic [31:0] issued_ids [$];
    logic [47:0] clock_ms = 48'd1000;
    int          errors = 0;
    int          burst_left = 0;

    // Expected results of one accepted request, pushed in output order.
    task automatic predict_results(input req_t r);
        int   used, free_slot, pick;
        logic [31:0] prev_id, total;
        bit   have_prev;
        logic [63:0] sleep, left, elapsed;
        used = 0;
        free_slot = -1;
        case (r.cmd)
            CMD_ADD: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (slot_on[i]) used++;
                    else if (free_slot < 0) free_slot = i;
                end
                if (used >= active_limit || free_slot < 0) begin
                    pending_results.push_back('{KIND_ADD_REFUSED, 32'd0, 16'd0, 20'd0, 1'b1});
                end else begin
                    id_counter = id_counter + 32'd1;
                    if (id_counter == ID_WRAP) id_counter = 32'd1;
                    pick = -1;
                    for (int i = 0; i < NSLOT; i++)
                        if (slot_on[i] && slot_tid[i] == id_counter) pick = i;
                    if (pick >= 0) begin
                        pending_results.push_back(
                            '{KIND_ADD_REFUSED, 32'd0, 16'd0, 20'd0, 1'b1});
                    end else begin
                        slot_on[free_slot] = 1'b1;
                        slot_tid[free_slot] = id_counter;
                        slot_period[free_slot] = r.interval;
                        slot_begin[free_slot] = r.now;
                        slot_fires[free_slot] = '0;
                        slot_total[free_slot] = r.repeats;
                        issued_ids.push_back(id_counter);
                        pending_results.push_back(
                            '{KIND_ADD_OK, id_counter, 16'd0, 20'd0, 1'b1});
                    end
                end
            end
            CMD_STOP: begin
                for (int i = 0; i < NSLOT; i++)
                    if (slot_on[i] && slot_tid[i] == r.tid) slot_on[i] = 1'b0;
                pending_results.push_back('{KIND_STOP_DONE, 32'd0, 16'd0, 20'd0, 1'b1});
            end
            CMD_STOP_ALL: begin
                for (int i = 0; i < NSLOT; i++) slot_on[i] = 1'b0;
                pending_results.push_back('{KIND_CLEAR_DONE, 32'd0, 16'd0, 20'd0, 1'b1});
            end
            default: begin
                // Timers are visited in ascending id order, not slot order.
                sleep = 64'(SLEEP_NONE);
                have_prev = 1'b0;
                prev_id = '0;
                forever begin
                    pick = -1;
                    for (int i = 0; i < NSLOT; i++) begin
                        if (!slot_on[i]) continue;
                        if (have_prev && slot_tid[i] <= prev_id) continue;
                        if (pick < 0 || slot_tid[i] < slot_tid[pick]) pick = i;
                    end
                    if (pick < 0) break;
                    prev_id = slot_tid[pick];
                    have_prev = 1'b1;
                    elapsed = 64'(r.now) - 64'(slot_begin[pick]);
                    if (r.now < slot_begin[pick]) begin
                        // Time went backwards: no expiry, the gap adds to the wait.
                        left = 64'(slot_period[pick]) + 64'(slot_begin[pick] - r.now);
                    end else if (elapsed < 64'(slot_period[pick])) begin
                        left = 64'(slot_period[pick]) - elapsed;
                    end else begin
                        total = (slot_total[pick] == 0) ? 32'd1 : 32'(slot_total[pick]);
                        slot_fires[pick] = slot_fires[pick] + 16'd1;
                        pending_results.push_back(
                            '{KIND_EXPIRY, slot_tid[pick], slot_fires[pick], 20'd0, 1'b0});
                        if (32'(slot_fires[pick]) >= total) begin
                            slot_on[pick] = 1'b0;
                            continue;
                        end
                        slot_begin[pick] = r.now;
                        left = 64'(slot_period[pick]);
                    end
                    if (left > 0 && left < sleep) sleep = left;
                end
                pending_results.push_back('{KIND_TICK_DONE, 32'd0, 16'd0, sleep[19:0], 1'b1});
            end
        endcase
    endtask

    // Sends one request; the sender keeps valid high within a burst and
    // drops it for a random gap between bursts.
    task automatic send_request(input req_t r);
        if (burst_left == 0) begin
            if (s_tvalid) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            repeat ($urandom_range(0, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tuser <= r.cmd;
        s_tdata <= {r.now, r.tid, r.repeats, r.interval};
        do @(posedge aclk); while (!s_tready);
        predict_results(r);
        burst_left--;
    endtask

    function automatic req_t make_req(input logic [1:0] cmd, input logic [31:0] interval,
                                      input logic [15:0] repeats, input logic [31:0] tid,
                                      input logic [47:0] now);
        make_req = '{cmd, interval, repeats, tid, now};
    endfunction

    // Lets every outstanding result drain, then a margin for the block to
    // settle, before the next register write.
    task automatic wait_drained();
        if (s_tvalid) s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (IDLE_WAIT) @(posedge aclk);
    endtask

    task automatic set_active_limit(input logic [4:0] value);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        active_limit = value;
    endtask

    // Extremes of the add fields, a plain stop, an unknown stop and clear-all.
    task automatic test_add_and_stop();
        send_request(make_req(CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 48'd0));
        send_request(make_req(CMD_ADD, 32'd0, 16'd0, 32'd0, 48'hFFFF_FFFF_FFFF));
        send_request(make_req(CMD_ADD, 32'd10, 16'd2, 32'h5555_5555, 48'd100));
        send_request(make_req(CMD_STOP, 32'd0, 16'd0, 32'd3, 48'd0));
        send_request(make_req(CMD_STOP, 32'hAAAA_AAAA, 16'hAAAA, 32'hDEAD_0000, 48'd0));
        send_request(make_req(CMD_STOP_ALL, 32'd0, 16'd0, 32'd0, 48'd0));
    endtask

    // Expiry with repeats, a zero total, zero interval and time going backwards.
    task automatic test_tick_cases();
        send_request(make_req(CMD_TICK, 32'd0, 16'd0, 32'd0, 48'd50));
        send_request(make_req(CMD_ADD, 32'd10, 16'd2, 32'd0, 48'd100));
        send_request(make_req(CMD_ADD, 32'd5, 16'd0, 32'd0, 48'd100));
        send_request(make_req(CMD_ADD, 32'd0, 16'd3, 32'd0, 48'd100));
        send_request(make_req(CMD_ADD, 32'd2_000_000, 16'd1, 32'd0, 48'd100));
        send_request(make_req(CMD_TICK, 32'd0, 16'd0, 32'd0, 48'd90));
        send_request(make_req(CMD_TICK, 32'd0, 16'd0, 32'd0, 48'd110));
        send_request(make_req(CMD_TICK, 32'd0, 16'd0, 32'd0, 48'd120));
        send_request(make_req(CMD_TICK, 32'd0, 16'd0, 32'd0, 48'hFFFF_FFFF_FFFF));
        send_request(make_req(CMD_STOP_ALL, 32'd0, 16'd0, 32'd0, 48'd0));
    endtask

    // A full table, then the limit at zero and at its widest setting.
    task automatic test_capacity();
        set_active_limit(5'd2);
        repeat (3) send_request(make_req(CMD_ADD, 32'd7, 16'd1, 32'd0, 48'd5));
        set_active_limit(5'd0);
        send_request(make_req(CMD_ADD, 32'd7, 16'd1, 32'd0, 48'd5));
        set_active_limit(5'd31);
        repeat (17) send_request(make_req(CMD_ADD, 32'($urandom_range(1, 9)), 16'd1, 32'd0,
                                          48'd5));
        send_request(make_req(CMD_TICK, 32'd0, 16'd0, 32'd0, 48'd20));
    endtask

    // Mostly coherent traffic around a moving clock, with random full-width
    // noise mixed in so every field bit toggles.
    task automatic test_random_traffic(input int count);
        req_t r;
        int   pick;
        for (int n = 0; n < count; n++) begin
            r = make_req(CMD_TICK, $urandom, 16'($urandom), $urandom, clock_ms);
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                r.cmd = CMD_ADD;
                if ($urandom_range(0, 19) != 0) r.interval = $urandom_range(0, 40);
                if ($urandom_range(0, 19) != 0) r.repeats = 16'($urandom_range(0, 4));
            end else if (pick < 55) begin
                r.cmd = CMD_STOP;
                if (issued_ids.size() != 0 && $urandom_range(0, 4) != 0)
                    r.tid = issued_ids[$urandom_range(0, issued_ids.size() - 1)];
            end else if (pick < 58) begin
                r.cmd = CMD_STOP_ALL;
            end else begin
                if ($urandom_range(0, 19) == 0) clock_ms = {$urandom, 16'($urandom)};
                else clock_ms = clock_ms + 48'($urandom_range(0, 30));
                r.now = clock_ms;
            end
            send_request(r);
        end
    endtask

    // Result stalls: always ready, coin flips, or a fixed duty pattern.
    int ready_mode = 0, mode_left = 0, cyc = 0;
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(20, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= (cyc % 5) > 1;
        endcase
    end

    // Checker: each result against the oldest expectation.
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result kind=%0d id=%0d", m_tuser, m_tdata[31:0]);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, m_tuser);
                    errors++;
                end
                if (m_tdata[31:0] !== want.rid) begin
                    $error("result_id: expected %0d, got %0d", want.rid, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[47:32] !== want.fires) begin
                    $error("fire_count: expected %0d, got %0d", want.fires, m_tdata[47:32]);
                    errors++;
                end
                if (m_tdata[67:48] !== want.sleep) begin
                    $error("sleep_ms: expected %0d, got %0d", want.sleep, m_tdata[67:48]);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves a request or a result.
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("multi_shot_timer_table_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_add_and_stop();
        test_tick_cases();
        test_capacity();
        set_active_limit(5'd16);
        test_random_traffic(130);
        set_active_limit(5'd4);
        test_random_traffic(90);
        set_active_limit(5'd1);
        test_random_traffic(60);
        set_active_limit(5'd16);
        test_random_traffic(90);
        wait_drained();
        if (errors == 0)
            $display("multi_shot_timer_table_tb: PASS");
        else
            $display("multi_shot_timer_table_tb: FAIL");
        $finish;
    end

endmodule

// File: multi_shot_timer_table.f
+incdir+rtl/core
rtl/core/mstt_pkg.sv
rtl/core/mstt_cell.sv
rtl/core/mstt_eval.sv
rtl/core/multi_shot_timer_table.sv
tb/multi_shot_timer_table_tb.sv
